>>> rtl/pgd_pkg.sv
// ----------------------------------------------------------------------------
// pgd_pkg
// Types, codes, constants and saturating helpers shared by the grid deposit
// block.
// ----------------------------------------------------------------------------
package pgd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;
  localparam int DIM_REG_W  = 9;
  localparam int POS_W      = 32;
  localparam int INV_W      = 48;
  localparam int INV_LO_W   = 24;
  localparam int FRAC_W     = 48;
  localparam int MASS_IN_W  = 32;
  localparam int MASS_W     = 48;
  localparam int MOM_W      = 64;
  localparam int MOM_FRAC_W = 16;
  localparam int CNT_W      = 32;
  localparam int SPECIES_W  = 8;
  localparam int CELL_IN_W  = 16;
  localparam int DIM_MIN    = 16;

  localparam logic                  KIND_READ = 1'b1;
  localparam logic [SPECIES_W-1:0]  SPECIES_A = 8'd1;
  localparam logic [SPECIES_W-1:0]  SPECIES_B = 8'd2;

  localparam logic [DIM_REG_W-1:0]  RST_GRID_WIDTH  = 9'd256;
  localparam logic [DIM_REG_W-1:0]  RST_GRID_HEIGHT = 9'd80;
  localparam logic [INV_W-1:0]      RST_INV_LENGTH  = 48'h0001_0000_0000;

  localparam logic [MOM_W-1:0] MOM_ROUND = 64'h0000_0000_0000_FFFF;
  localparam logic signed [MOM_W-1:0] S64_MAX = {1'b0, {(MOM_W-1){1'b1}}};
  localparam logic signed [MOM_W-1:0] S64_MIN = {1'b1, {(MOM_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH   = 3'd0,
    CFG_GRID_HEIGHT  = 3'd1,
    CFG_INV_LENGTH_X = 3'd2,
    CFG_INV_LENGTH_Y = 3'd3,
    CFG_PERIODIC_X   = 3'd4,
    CFG_PERIODIC_Y   = 3'd5
  } cfg_reg_e;

  typedef enum logic {
    OP_DEPOSIT = 1'b0,
    OP_READ    = 1'b1
  } pgd_op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_MAP,
    ST_DEP_WR,
    ST_RD_WAIT,
    ST_RD_DATA
  } pgd_state_e;

  typedef struct packed {
    logic [DIM_REG_W-1:0] grid_width;
    logic [DIM_REG_W-1:0] grid_height;
    logic [INV_W-1:0]     inv_length_x;
    logic [INV_W-1:0]     inv_length_y;
    logic                 periodic_x;
    logic                 periodic_y;
  } pgd_cfg_t;

  typedef struct packed {
    logic                    valid;
    pgd_op_e                 op;
    logic [MASS_IN_W-1:0]    mass;
    logic signed [MOM_W-1:0] mom_x;
    logic signed [MOM_W-1:0] mom_y;
    logic                    is_a;
    logic                    is_b;
  } pgd_req_t;

  typedef struct packed {
    logic [MASS_W-1:0]       mass;
    logic [MASS_W-1:0]       mass_a;
    logic [MASS_W-1:0]       mass_b;
    logic signed [MOM_W-1:0] mom_x;
    logic signed [MOM_W-1:0] mom_y;
    logic [CNT_W-1:0]        cnt;
    logic [CNT_W-1:0]        cnt_a;
    logic [CNT_W-1:0]        cnt_b;
  } pgd_cell_t;

  function automatic logic [MASS_W-1:0] sat_add48(input logic [MASS_W-1:0] a,
                                                  input logic [MASS_W-1:0] b);
    logic [MASS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[MASS_W] ? {MASS_W{1'b1}} : s[MASS_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc32(input logic [CNT_W-1:0] a);
    return (&a) ? a : a + 1'b1;
  endfunction

  function automatic logic signed [MOM_W-1:0] sat_add64(
      input logic signed [MOM_W-1:0] a, input logic signed [MOM_W-1:0] b);
    logic signed [MOM_W-1:0] s;
    s = a + b;
    if ((a[MOM_W-1] == b[MOM_W-1]) && (s[MOM_W-1] != a[MOM_W-1])) begin
      s = a[MOM_W-1] ? S64_MIN : S64_MAX;
    end
    return s;
  endfunction

endpackage

>>> rtl/pgd_if.sv
// ----------------------------------------------------------------------------
// pgd_if
// Valid/ready channels of the grid deposit block: item in, cell sums out.
// ----------------------------------------------------------------------------
interface pgd_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic [31:0]        particle_mass;
  logic [7:0]         species;
  logic               is_fluid;
  logic [15:0]        read_cell;

  modport source (
    output valid, kind, pos_x, pos_y, vel_x, vel_y, particle_mass, species,
           is_fluid, read_cell,
    input  ready
  );
  modport sink (
    input  valid, kind, pos_x, pos_y, vel_x, vel_y, particle_mass, species,
           is_fluid, read_cell,
    output ready
  );
endinterface

interface pgd_out_if;
  logic               valid;
  logic               ready;
  logic [47:0]        mass_sum;
  logic [47:0]        mass_sum_a;
  logic [47:0]        mass_sum_b;
  logic signed [63:0] momentum_x;
  logic signed [63:0] momentum_y;
  logic [31:0]        count_all;
  logic [31:0]        count_a;
  logic [31:0]        count_b;

  modport source (
    output valid, mass_sum, mass_sum_a, mass_sum_b, momentum_x, momentum_y,
           count_all, count_a, count_b,
    input  ready
  );
  modport sink (
    input  valid, mass_sum, mass_sum_a, mass_sum_b, momentum_x, momentum_y,
           count_all, count_a, count_b,
    output ready
  );
endinterface

>>> rtl/pgd_axis.sv
// ----------------------------------------------------------------------------
// pgd_axis
// Six-stage mapping of one position coordinate to a cell column or row:
// scale by the inverse length, wrap or clamp, scale by the grid size, floor.
// ----------------------------------------------------------------------------
module pgd_axis import pgd_pkg::*; #(
  parameter int DW = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [POS_W-1:0] pos_i,
  input  logic [INV_W-1:0] inv_i,
  input  logic             periodic_i,
  input  logic [DW-1:0]    n_i,
  output logic             done_o,
  output logic [DW-1:0]    cell_o
);

  localparam int PW = POS_W + INV_W - INV_LO_W;
  localparam int FPW = FRAC_W + DW;

  logic [5:0]             vld_q;
  logic                   neg_q;
  logic [POS_W-1:0]       mag_q;
  logic [PW-1:0]          p0_q;
  logic [PW-1:0]          p1_q;
  logic [PW:0]            low;
  logic [FRAC_W-1:0]      frac_q;
  logic                   ip_nz_q;
  logic [FRAC_W-1:0]      fr_q;
  logic [FPW-1:0]         fprod;
  logic [DW-1:0]          fn_q;
  logic [DW-1:0]          cell_q;

  assign low   = (PW + 1)'(p0_q) + (PW + 1)'({p1_q[INV_LO_W-1:0], {INV_LO_W{1'b0}}});
  assign fprod = FPW'(fr_q) * FPW'(n_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= pos_i[POS_W-1];
      mag_q <= pos_i[POS_W-1] ? (~pos_i + 1'b1) : pos_i;
    end
    p0_q    <= PW'(mag_q) * PW'(inv_i[INV_LO_W-1:0]);
    p1_q    <= PW'(mag_q) * PW'(inv_i[INV_W-1:INV_LO_W]);
    frac_q  <= low[FRAC_W-1:0];
    ip_nz_q <= (|p1_q[PW-1:INV_LO_W]) || (|low[PW:FRAC_W]);
    fr_q    <= (periodic_i && neg_q) ? (~frac_q + 1'b1) : frac_q;
    fn_q    <= fprod[FPW-1:FRAC_W];
    if (periodic_i) begin
      cell_q <= fn_q;
    end else if (neg_q) begin
      cell_q <= '0;
    end else if (ip_nz_q) begin
      cell_q <= n_i - 1'b1;
    end else begin
      cell_q <= fn_q;
    end
  end

  assign done_o = vld_q[5];
  assign cell_o = cell_q;

endmodule

>>> rtl/pgd_map.sv
// ----------------------------------------------------------------------------
// pgd_map
// Cell index and momentum of one particle: two axis pipelines, the momentum
// products and the row times width plus column step.
// ----------------------------------------------------------------------------
module pgd_map import pgd_pkg::*; #(
  parameter int GRID_DIM_MAX = 256,
  parameter int CW = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [POS_W-1:0]        pos_x_i,
  input  logic [POS_W-1:0]        pos_y_i,
  input  logic [POS_W-1:0]        vel_x_i,
  input  logic [POS_W-1:0]        vel_y_i,
  input  logic [MASS_IN_W-1:0]    mass_i,
  input  pgd_cfg_t                cfg_i,
  output logic                    done_o,
  output logic [CW-1:0]           cell_o,
  output logic signed [MOM_W-1:0] mom_x_o,
  output logic signed [MOM_W-1:0] mom_y_o
);

  localparam int DW  = $clog2(GRID_DIM_MAX + 1);
  localparam int DW2 = 2 * DW;
  localparam int QW  = MOM_W - MOM_FRAC_W;

  logic [DW-1:0]              dim_w;
  logic [DW-1:0]              dim_h;
  logic                       done_x;
  logic                       done_y;
  logic [DW-1:0]              col;
  logic [DW-1:0]              row;
  logic [DW2-1:0]             row_w;
  logic                       done_q;
  logic [CW-1:0]              cell_q;
  logic [1:0][POS_W-1:0]      vel;
  logic [1:0]                 vneg_q;
  logic [1:0][POS_W-1:0]      vmag_q;
  logic [MASS_IN_W-1:0]       mass_q;
  logic [1:0][MOM_W-1:0]      prod_q;
  logic [1:0][QW-1:0]         quo_q;
  logic [1:0][MOM_W-1:0]      mom_q;

  function automatic logic [DW-1:0] clamp_dim(input logic [DIM_REG_W-1:0] n);
    logic [DW-1:0] r;
    if (32'(n) < 32'(DIM_MIN)) begin
      r = DW'(DIM_MIN);
    end else if (32'(n) > 32'(GRID_DIM_MAX)) begin
      r = DW'(GRID_DIM_MAX);
    end else begin
      r = DW'(n);
    end
    return r;
  endfunction

  assign dim_w = clamp_dim(cfg_i.grid_width);
  assign dim_h = clamp_dim(cfg_i.grid_height);

  pgd_axis #(.DW(DW)) u_axis_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .pos_i      (pos_x_i),
    .inv_i      (cfg_i.inv_length_x),
    .periodic_i (cfg_i.periodic_x),
    .n_i        (dim_w),
    .done_o     (done_x),
    .cell_o     (col)
  );

  pgd_axis #(.DW(DW)) u_axis_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .pos_i      (pos_y_i),
    .inv_i      (cfg_i.inv_length_y),
    .periodic_i (cfg_i.periodic_y),
    .n_i        (dim_h),
    .done_o     (done_y),
    .cell_o     (row)
  );

  assign row_w = DW2'(row) * DW2'(dim_w);
  assign vel   = {vel_y_i, vel_x_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= done_x && done_y;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= CW'(row_w) + CW'(col);
    if (start_i) begin
      mass_q <= mass_i;
    end
    for (int i = 0; i < 2; i++) begin
      if (start_i) begin
        vneg_q[i] <= vel[i][POS_W-1];
        vmag_q[i] <= vel[i][POS_W-1] ? (~vel[i] + 1'b1) : vel[i];
      end
      prod_q[i] <= MOM_W'(mass_q) * MOM_W'(vmag_q[i]);
      quo_q[i]  <= vneg_q[i] ? QW'((prod_q[i] + MOM_ROUND) >> MOM_FRAC_W)
                             : prod_q[i][MOM_W-1:MOM_FRAC_W];
      mom_q[i]  <= vneg_q[i] ? (~MOM_W'(quo_q[i]) + 1'b1) : MOM_W'(quo_q[i]);
    end
  end

  assign done_o  = done_q;
  assign cell_o  = cell_q;
  assign mom_x_o = mom_q[0];
  assign mom_y_o = mom_q[1];

endmodule

>>> rtl/pgd_store.sv
// ----------------------------------------------------------------------------
// pgd_store
// Cell sum memory: read, saturating update or clear, write back. Sweeps the
// memory to zero after reset.
// ----------------------------------------------------------------------------
module pgd_store import pgd_pkg::*; #(
  parameter int CELL_COUNT = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pgd_req_t        req_i,
  input  logic [$clog2(CELL_COUNT)-1:0] addr_i,
  output logic            ready_o,
  output logic            rsp_valid_o,
  output pgd_cell_t       rsp_data_o
);

  localparam int AW = $clog2(CELL_COUNT);

  pgd_cell_t         mem_q [CELL_COUNT];
  pgd_cell_t         rd_q;
  pgd_req_t          req_q;
  logic [AW-1:0]     addr_q;
  logic              clr_q;
  logic [AW-1:0]     clr_addr_q;
  pgd_cell_t         upd;
  logic              we;
  logic [AW-1:0]     waddr;
  pgd_cell_t         wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      req_q      <= '0;
    end else begin
      req_q <= req_i;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(CELL_COUNT - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      addr_q <= addr_i;
    end
  end

  always_comb begin
    upd = rd_q;
    unique case (req_q.op)
      OP_DEPOSIT: begin
        upd.mass  = sat_add48(rd_q.mass, MASS_W'(req_q.mass));
        upd.mom_x = sat_add64(rd_q.mom_x, req_q.mom_x);
        upd.mom_y = sat_add64(rd_q.mom_y, req_q.mom_y);
        upd.cnt   = sat_inc32(rd_q.cnt);
        if (req_q.is_a) begin
          upd.mass_a = sat_add48(rd_q.mass_a, MASS_W'(req_q.mass));
          upd.cnt_a  = sat_inc32(rd_q.cnt_a);
        end
        if (req_q.is_b) begin
          upd.mass_b = sat_add48(rd_q.mass_b, MASS_W'(req_q.mass));
          upd.cnt_b  = sat_inc32(rd_q.cnt_b);
        end
      end
      OP_READ: upd = '0;
    endcase
  end

  assign we    = clr_q || req_q.valid;
  assign waddr = clr_q ? clr_addr_q : addr_q;
  assign wdata = clr_q ? '0 : upd;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (req_i.valid) begin
      rd_q <= mem_q[addr_i];
    end
  end

  assign ready_o     = !clr_q;
  assign rsp_valid_o = req_q.valid && (req_q.op == OP_READ);
  assign rsp_data_o  = rd_q;

endmodule

>>> rtl/particle_grid_deposit.sv
// ----------------------------------------------------------------------------
// particle_grid_deposit
// Nearest grid point deposition of particles into a cell store, with
// read-and-clear of single cells.
//
//   port         dir   word
//   deposit_i    sink  deposit particle, or read and clear one cell
//   result_o     src   eight saturated sums of one cell, one per read word
//   cfg_we_i     in    register write, index cfg_index_i, data cfg_data_i
//
// no word is accepted while a deposit passes the six-stage axis mapping,
// the cell index multiply and the memory read-modify-write; a skipped
// non-fluid word leaves the block idle and ready for the next word
// a read waits until the output register is free
// after reset the memory is swept to zero, cell by cell, and no word
// is accepted meanwhile
// a result waiting in the output register stalls only the next read word
// ----------------------------------------------------------------------------
module particle_grid_deposit import pgd_pkg::*; #(
  parameter int GRID_DIM_MAX = 256,
  parameter int CELL_COUNT   = 65536
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  pgd_in_if.sink                deposit_i,
  pgd_out_if.source             result_o
);

  localparam int CW = $clog2(GRID_DIM_MAX * GRID_DIM_MAX);
  localparam int AW = $clog2(CELL_COUNT);

  pgd_state_e              state_q, state_d;
  pgd_cfg_t                cfg_q;
  logic                    in_fire;
  logic                    map_start;
  logic                    map_done;
  logic [CW-1:0]           map_cell;
  logic signed [MOM_W-1:0] map_mom_x;
  logic signed [MOM_W-1:0] map_mom_y;
  logic [MASS_IN_W-1:0]    mass_q;
  logic                    is_a_q;
  logic                    is_b_q;
  logic [CELL_IN_W-1:0]    rd_cell_q;
  logic                    cell_ok;
  logic                    rd_ok;
  pgd_req_t                store_req;
  logic [AW-1:0]           store_addr;
  logic                    store_ready;
  logic                    store_rsp_valid;
  pgd_cell_t               store_rsp;
  logic                    out_valid_q;
  pgd_cell_t               out_q;
  logic                    out_free;
  logic                    out_load;
  logic                    out_zero;

  assign deposit_i.ready = (state_q == ST_IDLE);
  assign in_fire  = deposit_i.valid && deposit_i.ready;
  assign cell_ok  = 32'(map_cell) < 32'(CELL_COUNT);
  assign rd_ok    = 32'(rd_cell_q) < 32'(CELL_COUNT);
  assign out_free = !out_valid_q || result_o.ready;
  assign store_addr = (state_q == ST_MAP) ? AW'(map_cell) : AW'(rd_cell_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.grid_width   <= RST_GRID_WIDTH;
      cfg_q.grid_height  <= RST_GRID_HEIGHT;
      cfg_q.inv_length_x <= RST_INV_LENGTH;
      cfg_q.inv_length_y <= RST_INV_LENGTH;
      cfg_q.periodic_x   <= 1'b1;
      cfg_q.periodic_y   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_GRID_WIDTH:   cfg_q.grid_width   <= cfg_data_i[DIM_REG_W-1:0];
        CFG_GRID_HEIGHT:  cfg_q.grid_height  <= cfg_data_i[DIM_REG_W-1:0];
        CFG_INV_LENGTH_X: cfg_q.inv_length_x <= cfg_data_i[INV_W-1:0];
        CFG_INV_LENGTH_Y: cfg_q.inv_length_y <= cfg_data_i[INV_W-1:0];
        CFG_PERIODIC_X:   cfg_q.periodic_x   <= cfg_data_i[0];
        CFG_PERIODIC_Y:   cfg_q.periodic_y   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mass_q    <= deposit_i.particle_mass;
      is_a_q    <= (deposit_i.species == SPECIES_A);
      is_b_q    <= (deposit_i.species == SPECIES_B);
      rd_cell_q <= deposit_i.read_cell;
    end
  end

  pgd_map #(
    .GRID_DIM_MAX (GRID_DIM_MAX),
    .CW           (CW)
  ) u_map (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (map_start),
    .pos_x_i (deposit_i.pos_x),
    .pos_y_i (deposit_i.pos_y),
    .vel_x_i (deposit_i.vel_x),
    .vel_y_i (deposit_i.vel_y),
    .mass_i  (deposit_i.particle_mass),
    .cfg_i   (cfg_q),
    .done_o  (map_done),
    .cell_o  (map_cell),
    .mom_x_o (map_mom_x),
    .mom_y_o (map_mom_y)
  );

  pgd_store #(.CELL_COUNT(CELL_COUNT)) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (store_req),
    .addr_i      (store_addr),
    .ready_o     (store_ready),
    .rsp_valid_o (store_rsp_valid),
    .rsp_data_o  (store_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    map_start = 1'b0;
    store_req = '0;
    out_load  = 1'b0;
    out_zero  = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        if (store_ready) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          if (deposit_i.kind == KIND_READ) begin
            state_d = ST_RD_WAIT;
          end else if (deposit_i.is_fluid) begin
            map_start = 1'b1;
            state_d   = ST_MAP;
          end
        end
      end
      ST_MAP: begin
        if (map_done) begin
          if (cell_ok) begin
            store_req.valid = 1'b1;
            store_req.op    = OP_DEPOSIT;
            store_req.mass  = mass_q;
            store_req.mom_x = map_mom_x;
            store_req.mom_y = map_mom_y;
            store_req.is_a  = is_a_q;
            store_req.is_b  = is_b_q;
            state_d         = ST_DEP_WR;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_DEP_WR: begin
        state_d = ST_IDLE;
      end
      ST_RD_WAIT: begin
        if (out_free) begin
          if (rd_ok) begin
            store_req.valid = 1'b1;
            store_req.op    = OP_READ;
            state_d         = ST_RD_DATA;
          end else begin
            out_load = 1'b1;
            out_zero = 1'b1;
            state_d  = ST_IDLE;
          end
        end
      end
      ST_RD_DATA: begin
        out_load = 1'b1;
        state_d  = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_zero ? '0 : store_rsp;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.mass_sum   = out_q.mass;
  assign result_o.mass_sum_a = out_q.mass_a;
  assign result_o.mass_sum_b = out_q.mass_b;
  assign result_o.momentum_x = out_q.mom_x;
  assign result_o.momentum_y = out_q.mom_y;
  assign result_o.count_all  = out_q.cnt;
  assign result_o.count_a    = out_q.cnt_a;
  assign result_o.count_b    = out_q.cnt_b;

  ap_read_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (store_req.valid && (store_req.op == OP_READ)) |=> store_rsp_valid)
    else $error("store read gave no response");

  ap_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || result_o.ready))
    else $error("output register overwritten");

  ap_map_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_done |-> (state_q == ST_MAP))
    else $error("mapping finished outside its state");

  ap_req_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_req.valid |-> store_ready)
    else $error("store access during clearing sweep");

endmodule

>>> dv/particle_grid_deposit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_grid_deposit_tb
// Drives deposit and read words into the grid deposit block and checks every
// returned cell against a cycle-free model of the cell store or a typed table
// row. A short table of directed words leads random phases under several grid
// setups, with random gaps on both channels in all phases but the last.
// ----------------------------------------------------------------------------
module particle_grid_deposit_tb;
  import pgd_pkg::*;

  localparam int          GRID_DIM_MAX  = 256;
  localparam int          CELL_COUNT    = 65536;
  localparam int          PHASE_WORDS   = 145;
  localparam int          SETTLE_CYCLES = 16;
  localparam int          MAX_REPORTS   = 10;
  localparam int unsigned CYCLE_LIMIT   = 400_000;

  typedef struct packed {
    pgd_op_e            kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic [31:0]        particle_mass;
    logic [7:0]         species;
    logic               is_fluid;
    logic [15:0]        read_cell;
  } in_word_t;

  typedef struct packed {
    logic [47:0]        mass_sum;
    logic [47:0]        mass_sum_a;
    logic [47:0]        mass_sum_b;
    logic signed [63:0] momentum_x;
    logic signed [63:0] momentum_y;
    logic [31:0]        count_all;
    logic [31:0]        count_a;
    logic [31:0]        count_b;
  } cell_sums_t;

  typedef struct {
    in_word_t   word;
    bit         typed;
    cell_sums_t sums;
  } table_row_t;

  localparam cell_sums_t UNIT_A_SUMS = '{48'h1_0000, 48'h1_0000, 48'h0, 64'sh1_0000,
                                         -64'sh1_0000, 32'd1, 32'd1, 32'd0};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  take_ready = 1'b0;
  int unsigned           cycle_cnt = 0;
  int unsigned           send_idle_pct;
  int unsigned           recv_idle_pct;
  int                    mismatches = 0;

  pgd_cfg_t              grid_cfg;
  pgd_cfg_t              phase_cfgs [3];
  cell_sums_t            grid_sums [CELL_COUNT];
  cell_sums_t            pending_sums [$];
  cell_sums_t            due_sums;
  logic [15:0]           touched_cells [$];
  table_row_t            table_rows [$];

  pgd_in_if  word_in ();
  pgd_out_if sums_out ();

  assign sums_out.ready = take_ready;

  particle_grid_deposit #(
    .GRID_DIM_MAX (GRID_DIM_MAX),
    .CELL_COUNT   (CELL_COUNT)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .deposit_i   (word_in),
    .result_o    (sums_out)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("particle_grid_deposit: mismatch");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    take_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---- cell store model ----

  function automatic logic [8:0] used_dim(input logic [8:0] r);
    if (r < DIM_MIN) return 9'(DIM_MIN);
    if (r > GRID_DIM_MAX) return 9'(GRID_DIM_MAX);
    return r;
  endfunction

  function automatic logic [8:0] axis_cell_index(input logic [31:0] pos,
                                                 input logic [47:0] inv,
                                                 input logic wrap,
                                                 input logic [8:0] n);
    logic        neg;
    logic [31:0] mag;
    logic [79:0] prod;
    logic [47:0] frac;
    logic [31:0] whole;
    logic [63:0] c;
    neg   = pos[31];
    mag   = neg ? -pos : pos;
    prod  = 80'(mag) * 80'(inv);
    frac  = prod[47:0];
    whole = prod[79:48];
    if (wrap) begin
      // floor semantics: a negative position wraps to one minus its fraction
      if (neg) frac = -frac;
      c = (64'(frac) * 64'(n)) >> 48;
    end else begin
      if (neg) return '0;
      if (32'(whole) >= 32'(n)) return n - 9'd1;
      c = 64'(whole) * 64'(n) + ((64'(frac) * 64'(n)) >> 48);
    end
    return (c >= 64'(n)) ? n - 9'd1 : c[8:0];
  endfunction

  function automatic logic signed [63:0] mass_times_vel(input logic [31:0] m,
                                                        input logic [31:0] v);
    logic        neg;
    logic [31:0] mag;
    logic [63:0] prod;
    logic [64:0] up;
    neg  = v[31];
    mag  = neg ? -v : v;
    prod = 64'(m) * 64'(mag);
    if (!neg) return $signed({16'h0, prod[63:16]});
    up = ({1'b0, prod} + 65'h0_FFFF) >> 16;
    return -$signed(up[63:0]);
  endfunction

  function automatic logic [47:0] add_sat_u48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

  function automatic logic [31:0] inc_sat_u32(input logic [31:0] a);
    return (&a) ? a : a + 32'd1;
  endfunction

  function automatic logic signed [63:0] add_sat_s64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) s = a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

  function automatic void accumulate_word(input in_word_t w, output bit emits,
                                          output cell_sums_t got);
    cell_sums_t  s;
    logic [8:0]  nx;
    logic [8:0]  ny;
    logic [8:0]  ix;
    logic [8:0]  iy;
    int unsigned cell_idx;
    emits = 1'b0;
    got   = '0;
    if (w.kind == OP_READ) begin
      emits    = 1'b1;
      cell_idx = 32'(w.read_cell);
      if (cell_idx < CELL_COUNT) begin
        got                 = grid_sums[cell_idx];
        grid_sums[cell_idx] = '0;
      end
      return;
    end
    if (!w.is_fluid) return;
    nx       = used_dim(grid_cfg.grid_width);
    ny       = used_dim(grid_cfg.grid_height);
    ix       = axis_cell_index(w.pos_x, grid_cfg.inv_length_x, grid_cfg.periodic_x, nx);
    iy       = axis_cell_index(w.pos_y, grid_cfg.inv_length_y, grid_cfg.periodic_y, ny);
    cell_idx = 32'(iy) * 32'(nx) + 32'(ix);
    if (cell_idx >= CELL_COUNT) return;
    s            = grid_sums[cell_idx];
    s.mass_sum   = add_sat_u48(s.mass_sum, 48'(w.particle_mass));
    s.momentum_x = add_sat_s64(s.momentum_x, mass_times_vel(w.particle_mass, w.vel_x));
    s.momentum_y = add_sat_s64(s.momentum_y, mass_times_vel(w.particle_mass, w.vel_y));
    s.count_all  = inc_sat_u32(s.count_all);
    if (w.species == SPECIES_A) begin
      s.mass_sum_a = add_sat_u48(s.mass_sum_a, 48'(w.particle_mass));
      s.count_a    = inc_sat_u32(s.count_a);
    end else if (w.species == SPECIES_B) begin
      s.mass_sum_b = add_sat_u48(s.mass_sum_b, 48'(w.particle_mass));
      s.count_b    = inc_sat_u32(s.count_b);
    end
    grid_sums[cell_idx] = s;
    touched_cells = {touched_cells, cell_idx[15:0]};
    if (touched_cells.size() > 24) void'(touched_cells.pop_front());
  endfunction

  // ---- stimulus ----

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h1_FFFF);
      2: return 32'($urandom_range(32'h3_FFFF)) - 32'h2_0000;
      default: begin
        case ($urandom_range(4))
          0: return 32'h0000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h8000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
    endcase
  endfunction

  function automatic in_word_t random_word();
    in_word_t    w;
    int unsigned cells;
    int unsigned pick;
    w.pos_x = rand_q16();
    w.pos_y = rand_q16();
    w.vel_x = rand_q16();
    w.vel_y = rand_q16();
    case ($urandom_range(5))
      0: w.particle_mass = 32'h0001_0000;
      1: w.particle_mass = $urandom_range(32'h3_FFFF);
      2: w.particle_mass = 32'hFFFF_FFFF;
      3: w.particle_mass = 32'h0;
      default: w.particle_mass = $urandom;
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3: w.species = SPECIES_A;
      4, 5, 6: w.species = SPECIES_B;
      7: w.species = 8'd0;
      default: w.species = 8'($urandom_range(255));
    endcase
    w.is_fluid  = ($urandom_range(99) < 85);
    w.read_cell = 16'($urandom);
    w.kind      = OP_DEPOSIT;
    if ($urandom_range(99) < 22) begin
      w.kind = OP_READ;
      cells  = 32'(used_dim(grid_cfg.grid_width)) * 32'(used_dim(grid_cfg.grid_height));
      pick   = $urandom_range(99);
      if (pick < 60 && touched_cells.size() != 0) begin
        w.read_cell = touched_cells[$urandom_range(touched_cells.size() - 1)];
      end else if (pick < 85) begin
        w.read_cell = 16'($urandom_range(cells - 1));
      end
    end
    return w;
  endfunction

  task automatic table_deposit(input logic [31:0] px, input logic [31:0] py,
                               input logic [31:0] vx, input logic [31:0] vy,
                               input logic [31:0] m, input logic [7:0] sp,
                               input logic fluid);
    table_row_t r;
    r.word  = '{OP_DEPOSIT, px, py, vx, vy, m, sp, fluid, 16'h0};
    r.typed = 1'b0;
    r.sums  = '0;
    table_rows = {table_rows, r};
  endtask

  task automatic table_read(input logic [15:0] cell_idx, input bit typed,
                            input cell_sums_t want);
    table_row_t r;
    r.word  = '{OP_READ, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 8'h0, 1'b0, cell_idx};
    r.typed = typed;
    r.sums  = want;
    table_rows = {table_rows, r};
  endtask

  task automatic push_word(input in_word_t w, input bit typed, input cell_sums_t want);
    bit         emits;
    cell_sums_t sums;
    while ($urandom_range(99) < send_idle_pct) begin
      word_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    word_in.valid         <= 1'b1;
    word_in.kind          <= w.kind;
    word_in.pos_x         <= w.pos_x;
    word_in.pos_y         <= w.pos_y;
    word_in.vel_x         <= w.vel_x;
    word_in.vel_y         <= w.vel_y;
    word_in.particle_mass <= w.particle_mass;
    word_in.species       <= w.species;
    word_in.is_fluid      <= w.is_fluid;
    word_in.read_cell     <= w.read_cell;
    @(posedge clk_i);
    while (!word_in.ready) @(posedge clk_i);
    accumulate_word(w, emits, sums);
    if (emits) pending_sums = {pending_sums, (typed ? want : sums)};
  endtask

  // hold the sender until every read has come back, then let a deposit drain
  task automatic settle();
    word_in.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
  endtask

  task automatic apply_grid_cfg(input pgd_cfg_t c);
    write_reg(CFG_GRID_WIDTH, 48'(c.grid_width));
    write_reg(CFG_GRID_HEIGHT, 48'(c.grid_height));
    write_reg(CFG_INV_LENGTH_X, c.inv_length_x);
    write_reg(CFG_INV_LENGTH_Y, c.inv_length_y);
    write_reg(CFG_PERIODIC_X, 48'(c.periodic_x));
    write_reg(CFG_PERIODIC_Y, 48'(c.periodic_y));
    cfg_we_i <= 1'b0;
    grid_cfg = c;
  endtask

  // ---- result check ----

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%s differs: expected %h, got %h", field, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && sums_out.valid && sums_out.ready) begin
      if (pending_sums.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("result word with no read pending");
      end else begin
        due_sums = pending_sums.pop_front();
        compare_field("mass_sum", 64'(due_sums.mass_sum), 64'(sums_out.mass_sum));
        compare_field("mass_sum_a", 64'(due_sums.mass_sum_a), 64'(sums_out.mass_sum_a));
        compare_field("mass_sum_b", 64'(due_sums.mass_sum_b), 64'(sums_out.mass_sum_b));
        compare_field("momentum_x", due_sums.momentum_x, sums_out.momentum_x);
        compare_field("momentum_y", due_sums.momentum_y, sums_out.momentum_y);
        compare_field("count_all", 64'(due_sums.count_all), 64'(sums_out.count_all));
        compare_field("count_a", 64'(due_sums.count_a), 64'(sums_out.count_a));
        compare_field("count_b", 64'(due_sums.count_b), 64'(sums_out.count_b));
      end
    end
  end

  // ---- sequence ----

  initial begin
    in_word_t    w;
    int          counted;
    int unsigned send_idle_by_phase [3];
    int unsigned recv_idle_by_phase [3];

    send_idle_by_phase = '{20, 77, 0};
    recv_idle_by_phase = '{77, 20, 0};
    phase_cfgs[0] = '{9'd16, 9'd16, 48'h0001_0000_0000, 48'h0001_0000_0000, 1'b1, 1'b1};
    phase_cfgs[1] = '{9'd511, 9'd256, 48'h0000_4000_0000, 48'h0000_8000_0000, 1'b0, 1'b0};
    phase_cfgs[2] = '{9'd0, 9'd200, 48'h0, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0};
    grid_cfg = '{RST_GRID_WIDTH, RST_GRID_HEIGHT, RST_INV_LENGTH, RST_INV_LENGTH, 1'b1, 1'b1};
    foreach (grid_sums[i]) grid_sums[i] = '0;
    send_idle_pct = send_idle_by_phase[0];
    recv_idle_pct = recv_idle_by_phase[0];

    cfg_we_i              <= 1'b0;
    cfg_index_i           <= CFG_GRID_WIDTH;
    cfg_data_i            <= '0;
    word_in.valid         <= 1'b0;
    word_in.kind          <= OP_DEPOSIT;
    word_in.pos_x         <= '0;
    word_in.pos_y         <= '0;
    word_in.vel_x         <= '0;
    word_in.vel_y         <= '0;
    word_in.particle_mass <= '0;
    word_in.species       <= '0;
    word_in.is_fluid      <= 1'b0;
    word_in.read_cell     <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset grid: 256 x 80, unit domain, both axes wrap
    table_read(16'd0, 1'b1, '0);
    table_read(16'hFFFF, 1'b1, '0);
    table_deposit(32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, SPECIES_A, 1'b1);
    table_read(16'd0, 1'b1, UNIT_A_SUMS);
    table_deposit(32'h0, 32'h0, 32'h1234_5678, 32'h0001_0000, 32'h0001_0000, SPECIES_B, 1'b0);
    table_read(16'd0, 1'b1, '0);
    table_deposit(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'hFFFF_FFFF, SPECIES_B, 1'b1);
    table_deposit(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'hFFFF_FFFF, SPECIES_B, 1'b1);
    table_read(16'd255, 1'b0, '0);
    table_deposit(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 8'd0, 1'b1);
    table_read(16'd20479, 1'b0, '0);
    table_deposit(32'h0000_8000, 32'h0000_8000, 32'h8000_0000, 32'h8000_0000,
                  32'hFFFF_FFFF, 8'd255, 1'b1);
    table_deposit(32'h0000_8000, 32'h0000_8000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h0001_0000, SPECIES_A, 1'b1);
    table_deposit(32'h0000_8000, 32'h0000_8000, 32'hFFFF_FFFF, 32'h0000_0001,
                  32'h0000_0001, SPECIES_B, 1'b1);
    table_read(16'd10368, 1'b0, '0);
    table_read(16'd20480, 1'b1, '0);
    table_deposit(32'h0001_0000, 32'h0050_0000, 32'hFFFF_8000, 32'h0000_8000,
                  32'h0001_0000, 8'd0, 1'b1);
    table_read(16'd0, 1'b0, '0);

    foreach (table_rows[i]) push_word(table_rows[i].word, table_rows[i].typed,
                                      table_rows[i].sums);
    settle();

    for (int p = 0; p < 3; p++) begin
      apply_grid_cfg(phase_cfgs[p]);
      send_idle_pct = send_idle_by_phase[p];
      recv_idle_pct = recv_idle_by_phase[p];
      counted = 0;
      while (counted < PHASE_WORDS) begin
        w = random_word();
        push_word(w, 1'b0, '0);
        counted++;
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("particle_grid_deposit: match");
    end else begin
      $display("particle_grid_deposit: mismatch");
    end
    $finish;
  end

endmodule
